[hw/rtl/pbcl_pkg.sv]
// Package for the projection blob centroid locator.
// Holds default sizes, register reset values, register codes and the sequencer state type.
// No dependencies.
package pbcl_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 64;

  localparam logic [7:0] ROI_WIDTH_RESET  = 8'd160;
  localparam logic [6:0] ROI_HEIGHT_RESET = 7'd60;

  // Register select is address bit 2.
  localparam logic REG_ROI_WIDTH  = 1'b0;
  localparam logic REG_ROI_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PIX,
    S_CSCAN,
    S_XINIT,
    S_XSUM,
    S_XDIV,
    S_RBUILD,
    S_RSCAN,
    S_YINIT,
    S_YSUM,
    S_YDIV,
    S_OUT
  } state_t;

endpackage

[hw/rtl/projection_blob_centroid_locator_core.sv]
// Top level of the projection blob centroid locator: frame load, span scans and centroids.
// Depends on pbcl_pkg, pbcl_ram and pbcl_div.
//
// Each pixel transaction is a read-modify-write of the column count memory; the column
// counts need no clearing because the first row of every frame overwrites them. After the
// last pixel of a frame, in_stall stays high while a sequencer works through one memory word
// at a time: the column scan, then per slot the column sum, the row counts (one frame bit
// per read), the row scan, the row sum, and two divisions on the shared divider. The result
// is then held in an output register until taken, while the next frame already loads.
module projection_blob_centroid_locator_core #(
  parameter int MAX_WIDTH  = pbcl_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = pbcl_pkg::DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        pixel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  first_x,
  output logic [5:0]  first_y,
  output logic [7:0]  second_x,
  output logic [5:0]  second_y
);
  import pbcl_pkg::*;

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int IW  = (XW > YW) ? XW : YW;
  localparam int CCW = YW + 1;
  localparam int RCW = XW;
  localparam int MW  = (CCW > RCW) ? CCW : RCW;
  localparam int DW  = XW + YW + 1;
  localparam int NW  = XW + YW + 1 + IW;
  localparam int FAW = XW + YW;

  state_t state, state_next;

  logic [7:0]    roi_width;
  logic [6:0]    roi_height;
  logic [XW-1:0] col;
  logic [YW-1:0] row;
  logic          px_hold;
  logic          phase;
  logic [IW-1:0] idx;
  logic [XW-1:0] cidx;
  logic          slot;
  logic          toggle;
  logic          prev_nz;
  logic [XW-1:0] lb [2];
  logic [XW-1:0] rb [2];
  logic [YW-1:0] top;
  logic [YW-1:0] bot;
  logic [RCW-1:0] rowsum;
  logic [NW-1:0] num;
  logic [DW-1:0] den;
  logic [7:0]    qx [2];
  logic [5:0]    qy [2];

  logic [XW:0]   w_eff, w_last;
  logic [YW:0]   h_eff, h_last;
  logic          cfg_wr, in_acc, out_take;
  logic          col_last, row_last;
  logic [XW-1:0] left, right;
  logic          x_empty, y_empty;
  logic          idx_w_last, idx_h_last, idx_right, idx_bot, cidx_right;
  logic          loop_end;

  logic            cc_we;
  logic [XW-1:0]   cc_waddr, cc_raddr;
  logic [CCW-1:0]  cc_wdata, cc_rdata;
  logic            fb_we;
  logic [FAW-1:0]  fb_waddr, fb_raddr;
  logic            fb_rdata;
  logic            rc_we;
  logic [YW-1:0]   rc_addr;
  logic [RCW-1:0]  rc_wdata, rc_rdata;

  logic            div_start, div_done;
  logic [NW-1:0]   quot;
  logic [MW-1:0]   mul_cnt;
  logic [MW+IW-1:0] prod;
  logic            data_nz;
  logic            fb_bit;

  pbcl_ram #(.WIDTH(CCW), .DEPTH(MAX_WIDTH)) u_col_ram (
    .clk(clk), .we(cc_we), .waddr(cc_waddr), .wdata(cc_wdata),
    .raddr(cc_raddr), .rdata(cc_rdata)
  );

  pbcl_ram #(.WIDTH(1), .DEPTH(1 << FAW)) u_frame_ram (
    .clk(clk), .we(fb_we), .waddr(fb_waddr), .wdata(pixel),
    .raddr(fb_raddr), .rdata(fb_rdata)
  );

  pbcl_ram #(.WIDTH(RCW), .DEPTH(MAX_HEIGHT)) u_row_ram (
    .clk(clk), .we(rc_we), .waddr(rc_addr), .wdata(rc_wdata),
    .raddr(rc_addr), .rdata(rc_rdata)
  );

  pbcl_div #(.NW(NW), .DW(DW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(num), .den(den),
    .done(div_done), .quot(quot)
  );

  // Effective frame size.
  always_comb begin
    if (roi_width < 8'd2) begin
      w_eff = (XW+1)'(2);
    end else if (16'(roi_width) > 16'(MAX_WIDTH)) begin
      w_eff = (XW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (XW+1)'(roi_width);
    end
    if (roi_height < 7'd2) begin
      h_eff = (YW+1)'(2);
    end else if (16'(roi_height) > 16'(MAX_HEIGHT)) begin
      h_eff = (YW+1)'(MAX_HEIGHT);
    end else begin
      h_eff = (YW+1)'(roi_height);
    end
  end

  assign w_last   = w_eff - 1'b1;
  assign h_last   = h_eff - 1'b1;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign col_last = ({1'b0, col} == w_last);
  assign row_last = ({1'b0, row} == h_last);

  assign left       = lb[slot];
  assign right      = rb[slot];
  assign x_empty    = left > right;
  assign y_empty    = top > bot;
  assign idx_w_last = ({2'b00, idx} == (IW+2)'(w_last));
  assign idx_h_last = ({2'b00, idx} == (IW+2)'(h_last));
  assign idx_right  = (idx == IW'(right));
  assign idx_bot    = (idx == IW'(bot));
  assign cidx_right = (cidx == right);

  assign mul_cnt = (state == S_XSUM) ? MW'(cc_rdata) : MW'(rc_rdata);
  assign prod    = mul_cnt * idx;
  assign data_nz = (state == S_CSCAN) ? (cc_rdata != '0) : (rc_rdata != '0);
  assign fb_bit  = fb_rdata && !x_empty;

  always_comb begin
    case (paddr[2])
      REG_ROI_WIDTH:  prdata = {24'd0, roi_width};
      REG_ROI_HEIGHT: prdata = {25'd0, roi_height};
      default:        prdata = '0;
    endcase
  end

  // Loop end of the current scan or sum state.
  always_comb begin
    case (state)
      S_CSCAN:  loop_end = idx_w_last;
      S_XSUM:   loop_end = x_empty || idx_right;
      S_RBUILD: loop_end = (x_empty || cidx_right) && idx_h_last;
      S_RSCAN:  loop_end = idx_h_last;
      S_YSUM:   loop_end = y_empty || idx_bot;
      default:  loop_end = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) state_next = S_PIX;
      end
      S_PIX: begin
        state_next = (col_last && row_last) ? S_CSCAN : S_IDLE;
      end
      S_CSCAN: begin
        if (phase && loop_end) state_next = S_XINIT;
      end
      S_XINIT: state_next = S_XSUM;
      S_XSUM: begin
        if (phase && loop_end) state_next = S_XDIV;
      end
      S_XDIV: begin
        if (phase && div_done) state_next = S_RBUILD;
      end
      S_RBUILD: begin
        if (phase && loop_end) state_next = S_RSCAN;
      end
      S_RSCAN: begin
        if (phase && loop_end) state_next = S_YINIT;
      end
      S_YINIT: state_next = S_YSUM;
      S_YSUM: begin
        if (phase && loop_end) state_next = S_YDIV;
      end
      S_YDIV: begin
        if (phase && div_done) state_next = slot ? S_OUT : S_XINIT;
      end
      S_OUT: begin
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != S_IDLE);
    div_start = ((state == S_XDIV) || (state == S_YDIV)) && !phase;
    cc_we     = (state == S_PIX);
    cc_waddr  = col;
    cc_wdata  = ((row == '0) ? '0 : cc_rdata) + CCW'(px_hold);
    cc_raddr  = (state == S_IDLE) ? col : idx[XW-1:0];
    fb_we     = in_acc;
    fb_waddr  = {row, col};
    fb_raddr  = {idx[YW-1:0], cidx};
    rc_addr   = idx[YW-1:0];
    rc_we     = (state == S_RBUILD) && phase && (x_empty || cidx_right);
    rc_wdata  = rowsum + RCW'(fb_bit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      roi_width  <= ROI_WIDTH_RESET;
      roi_height <= ROI_HEIGHT_RESET;
      col        <= '0;
      row        <= '0;
      phase      <= 1'b0;
      out_valid  <= 1'b0;
      slot       <= 1'b0;
    end else begin
      state <= state_next;
      if (out_take) out_valid <= 1'b0;

      if (cfg_wr) begin
        if (paddr[2] == REG_ROI_WIDTH) begin
          roi_width <= pwdata[7:0];
        end else begin
          roi_height <= pwdata[6:0];
        end
        col <= '0;
        row <= '0;
      end

      case (state)
        S_IDLE: begin
          if (in_acc) px_hold <= pixel;
        end
        S_PIX: begin
          if (col_last) begin
            col <= '0;
            row <= row_last ? '0 : row + 1'b1;
          end else begin
            col <= col + 1'b1;
          end
          idx     <= '0;
          phase   <= 1'b0;
          toggle  <= 1'b0;
          slot    <= 1'b0;
          lb[0]   <= '0;
          lb[1]   <= '0;
          rb[0]   <= '0;
          rb[1]   <= '0;
        end
        S_CSCAN: begin
          phase <= !phase;
          if (phase) begin
            if (idx != '0) begin
              if (data_nz && !prev_nz) begin
                lb[toggle] <= idx[XW-1:0];
              end else if (!data_nz && prev_nz) begin
                rb[toggle] <= idx[XW-1:0] - 1'b1;
                toggle     <= !toggle;
              end
            end
            prev_nz <= data_nz;
            idx     <= idx + 1'b1;
          end
        end
        S_XINIT: begin
          idx   <= IW'(left);
          num   <= '0;
          den   <= '0;
          phase <= 1'b0;
        end
        S_XSUM: begin
          phase <= !phase;
          if (phase) begin
            if (!x_empty) begin
              num <= num + NW'(prod);
              den <= den + DW'(cc_rdata);
            end
            idx <= idx + 1'b1;
          end
        end
        S_XDIV: begin
          phase <= 1'b1;
          if (phase && div_done) begin
            qx[slot] <= 8'(quot);
            phase    <= 1'b0;
            idx      <= '0;
            cidx     <= left;
            rowsum   <= '0;
          end
        end
        S_RBUILD: begin
          phase <= !phase;
          if (phase) begin
            if (x_empty || cidx_right) begin
              rowsum <= '0;
              cidx   <= left;
              idx    <= idx + 1'b1;
              if (loop_end) begin
                idx <= '0;
                top <= '0;
                bot <= '0;
              end
            end else begin
              rowsum <= rc_wdata;
              cidx   <= cidx + 1'b1;
            end
          end
        end
        S_RSCAN: begin
          phase <= !phase;
          if (phase) begin
            if (idx != '0) begin
              if (data_nz && !prev_nz) begin
                top <= idx[YW-1:0];
              end else if (!data_nz && prev_nz) begin
                bot <= idx[YW-1:0] - 1'b1;
              end
            end
            prev_nz <= data_nz;
            idx     <= idx + 1'b1;
          end
        end
        S_YINIT: begin
          idx   <= IW'(top);
          num   <= '0;
          den   <= '0;
          phase <= 1'b0;
        end
        S_YSUM: begin
          phase <= !phase;
          if (phase) begin
            if (!y_empty) begin
              num <= num + NW'(prod);
              den <= den + DW'(rc_rdata);
            end
            idx <= idx + 1'b1;
          end
        end
        S_YDIV: begin
          phase <= 1'b1;
          if (phase && div_done) begin
            qy[slot] <= 6'(quot);
            phase    <= 1'b0;
            slot     <= 1'b1;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            first_x   <= qx[0];
            first_y   <= qy[0];
            second_x  <= qx[1];
            second_y  <= qy[1];
            out_valid <= 1'b1;
          end
        end
        default: begin
          phase <= 1'b0;
        end
      endcase
    end
  end

  a_accept_goes_pix: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_PIX))
    else $error("accepted pixel did not enter the count update");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_XDIV || state == S_YDIV))
    else $error("divider finished outside a division state");

  a_col_in_frame: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ({1'b0, col} < w_eff))
    else $error("column position outside the frame");

  a_out_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_valid && out_stall) |=> (state == S_OUT))
    else $error("new result overran a pending one");

endmodule

[hw/rtl/pbcl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pbcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/pbcl_div.sv]
// Restoring divider, one quotient bit per cycle; a zero divisor gives a zero quotient.
// No dependencies.
module pbcl_div #(
  parameter int NW = 23,
  parameter int DW = 15
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);

  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW:0]   rem;
  logic [NW-1:0] q;
  logic [DW-1:0] d;
  logic [DW:0]   sh;
  logic [DW+1:0] diff;
  logic          ge;

  assign sh   = {rem[DW-1:0], q[NW-1]};
  assign diff = {1'b0, sh} - {2'b00, d};
  assign ge   = !diff[DW+1];
  assign quot = (d == '0) ? '0 : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
        rem  <= '0;
        q    <= num;
        d    <= den;
      end else if (busy) begin
        rem <= ge ? diff[DW:0] : sh;
        q   <= {q[NW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
